### rtl/core/cfls_pkg.sv
package cfls_pkg;

    localparam int TIME_W  = 40;
    localparam int DUR_W   = 24;
    localparam int FORCE_W = 24;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = FORCE_W + DIFF_W;

    localparam logic [1:0] FUNC_WRITE_STEP  = 2'd0;
    localparam logic [1:0] FUNC_SET_EARLY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR_EARLY = 2'd2;
    localparam logic [1:0] FUNC_QUERY       = 2'd3;

    localparam logic [1:0] PH_DEFAULT   = 2'd0;
    localparam logic [1:0] PH_RAMP_DOWN = 2'd1;
    localparam logic [1:0] PH_SWING     = 2'd2;
    localparam logic [1:0] PH_RAMP_UP   = 2'd3;

    localparam logic [1:0] CFG_MAX_FORCE  = 2'd0;
    localparam logic [1:0] CFG_WALK_START = 2'd1;
    localparam logic [1:0] CFG_SIDE_MAP   = 2'd2;
    localparam logic [1:0] CFG_CONTACTS   = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [3:0]       slot;
        logic [DUR_W-1:0] double_contact_duration;
        logic [DUR_W-1:0] transition_duration;
        logic [DUR_W-1:0] swing_duration;
        logic             step_side;
        logic [2:0]       contact_index;
        logic [31:0]      time_value;
    } in_item_t;

    typedef struct packed {
        logic [FORCE_W-1:0] force_limit;
        logic [1:0]         phase_code;
    } out_item_t;

    typedef struct packed {
        logic             side;
        logic [DUR_W-1:0] swing;
        logic [DUR_W-1:0] trans;
        logic [DUR_W-1:0] dbl;
    } step_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_TS,
        S_TE,
        S_SE,
        S_SE2,
        S_CHK,
        S_MUL,
        S_DIVGO,
        S_DIVW,
        S_DONE
    } state_t;

endpackage

### rtl/core/cfls_div.sv
module cfls_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cfls_pkg::PROD_W-1:0] dividend,
    input  logic [cfls_pkg::DUR_W-1:0]  divisor,
    output logic                        done,
    output logic [cfls_pkg::PROD_W-1:0] quotient
);
    import cfls_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] num_reg, num_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DUR_W:0]    shifted;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[PROD_W-1]};
        fits     = shifted >= {1'b0, divisor};
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(PROD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? DUR_W'(shifted - {1'b0, divisor}) : shifted[DUR_W-1:0];
            num_next = {num_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### rtl/core/contact_force_limit_schedule.sv
// Contact force limit schedule. Load footsteps with write-step transfers and
// early contacts with set/clear transfers; these give no result. A query
// transfer walks the step table from the walk start, one memory read (S_FETCH)
// and then S_TS, S_TE, S_SE and S_SE2 per step, through a shared sum and
// window compare, and then computes a ramp with one multiply and a bit-serial
// divider. A query that resolves without a ramp or earlier in its step ends
// sooner. in_stall is high while a query runs; the result waits
// in an output register, and the next transfer is taken as soon as the walk
// has handed its result over.
module contact_force_limit_schedule #(
    parameter int MAX_STEPS    = 16,
    parameter int NUM_CONTACTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cfls_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cfls_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import cfls_pkg::*;

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int NW = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;

    state_t state_reg, state_next;

    logic [FORCE_W-1:0]     max_force_reg;
    logic [31:0]            walk_start_reg;
    logic [3:0]             side_map_reg;
    logic [2:0]             contacts_reg;

    step_entry_t            step_mem [MAX_STEPS];
    step_entry_t            rd_reg;
    logic [CW-1:0]          count_reg;
    logic [31:0]            early_mem [NUM_CONTACTS];
    logic [NUM_CONTACTS-1:0] early_valid_reg;

    logic [CW-1:0]          idx_reg, idx_next;
    logic [31:0]            t_reg, t_next;
    logic [31:0]            e_reg, e_next;
    logic                   has_e_reg, has_e_next;
    logic                   side_reg, side_next;
    logic                   early_ok_reg, early_ok_next;
    logic [TIME_W-1:0]      ts_reg, ts_next;
    logic [TIME_W-1:0]      te_reg, te_next;
    logic [TIME_W-1:0]      se_reg, se_next;
    logic [TIME_W-1:0]      org_reg, org_next;
    logic [1:0]             ph_reg, ph_next;
    logic [FORCE_W-1:0]     f_reg, f_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   accept;
    logic [TIME_W-1:0]      t_ext, e_ext, sum;
    logic                   in_win;
    logic [3:0]             limit;
    logic                   quick;
    logic                   div_done;
    logic [PROD_W-1:0]      quot;
    logic                   div_start;
    logic                   out_free;
    logic [DIFF_W-1:0]      diff;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == S_DIVGO);
    assign t_ext     = TIME_W'(t_reg);
    assign e_ext     = TIME_W'(e_reg);
    assign limit     = (4'(contacts_reg) < 4'(NUM_CONTACTS)) ? 4'(contacts_reg)
                                                              : 4'(NUM_CONTACTS);
    assign quick     = (4'(in_data.contact_index) >= limit)
                       || (in_data.time_value <= walk_start_reg) || (count_reg == '0);

    cfls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (rd_reg.trans),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.func == FUNC_QUERY)
                    state_next = quick ? S_DONE : S_FETCH;
            end
            S_FETCH: state_next = S_TS;
            S_TS:    state_next = S_TE;
            S_TE:    state_next = in_win ? S_CHK : S_SE;
            S_SE:    state_next = in_win ? S_CHK : S_SE2;
            S_SE2:
            begin
                if (in_win || (idx_reg + 1'b1 == count_reg))
                    state_next = S_CHK;
                else
                    state_next = S_FETCH;
            end
            S_CHK:
            begin
                if (side_reg != rd_reg.side || ph_reg == PH_DEFAULT
                    || ph_reg == PH_SWING || rd_reg.trans == '0)
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIVW;
            S_DIVW:  state_next = div_done ? S_DONE : S_DIVW;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        t_next        = t_reg;
        e_next        = e_reg;
        has_e_next    = has_e_reg;
        side_next     = side_reg;
        early_ok_next = early_ok_reg;
        ts_next       = ts_reg;
        te_next       = te_reg;
        se_next       = se_reg;
        org_next      = org_reg;
        ph_next       = ph_reg;
        f_next        = f_reg;
        prod_next     = prod_reg;
        sum           = '0;
        in_win        = 1'b0;
        diff          = DIFF_W'(t_ext - org_reg);
        case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                t_next     = in_data.time_value;
                e_next     = early_mem[NW'(in_data.contact_index)];
                has_e_next = (4'(in_data.contact_index) < 4'(NUM_CONTACTS))
                             && early_valid_reg[NW'(in_data.contact_index)];
                side_next  = (in_data.contact_index < 3'd4)
                             ? side_map_reg[in_data.contact_index[1:0]] : 1'b0;
                te_next    = TIME_W'(walk_start_reg);
                ph_next    = PH_DEFAULT;
                f_next     = max_force_reg;
            end
            S_TS:
            begin
                ts_next = te_reg + TIME_W'(rd_reg.dbl);
            end
            S_TE:
            begin
                sum     = ts_reg + TIME_W'(rd_reg.trans);
                in_win  = (t_ext >= ts_reg) && (t_ext <= sum);
                te_next = sum;
                if (in_win)
                begin
                    ph_next  = PH_RAMP_DOWN;
                    org_next = ts_reg;
                end
            end
            S_SE:
            begin
                sum           = te_reg + TIME_W'(rd_reg.swing);
                in_win        = (t_ext >= te_reg) && (t_ext <= sum);
                early_ok_next = has_e_reg && (e_ext >= te_reg) && (t_reg >= e_reg);
                se_next       = sum;
                if (in_win)
                begin
                    ph_next  = early_ok_next ? PH_RAMP_UP : PH_SWING;
                    org_next = e_ext;
                end
            end
            S_SE2:
            begin
                sum     = se_reg + TIME_W'(rd_reg.trans);
                in_win  = (t_ext >= se_reg) && (t_ext <= sum);
                te_next = sum;
                if (in_win)
                begin
                    ph_next  = PH_RAMP_UP;
                    org_next = early_ok_reg ? e_ext : se_reg;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_CHK:
            begin
                if (side_reg != rd_reg.side)
                begin
                    ph_next = PH_DEFAULT;
                    f_next  = max_force_reg;
                end
                else if (ph_reg == PH_SWING)
                    f_next = '0;
                else
                    f_next = max_force_reg;
            end
            S_MUL:
            begin
                prod_next = PROD_W'(max_force_reg) * PROD_W'(diff);
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    if (ph_reg == PH_RAMP_DOWN)
                        f_next = max_force_reg - FORCE_W'(quot);
                    else if (quot >= PROD_W'(max_force_reg))
                        f_next = max_force_reg;
                    else
                        f_next = FORCE_W'(quot);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_force_reg   <= FORCE_W'(24000);
            walk_start_reg  <= '0;
            side_map_reg    <= 4'd12;
            contacts_reg    <= 3'd4;
            count_reg       <= '0;
            early_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_FORCE:  max_force_reg  <= cfg_data[FORCE_W-1:0];
                    CFG_WALK_START: walk_start_reg <= cfg_data;
                    CFG_SIDE_MAP:   side_map_reg   <= cfg_data[3:0];
                    CFG_CONTACTS:   contacts_reg   <= cfg_data[2:0];
                    default:        contacts_reg   <= contacts_reg;
                endcase
            end
            if (accept && in_data.func == FUNC_WRITE_STEP
                && 9'(in_data.slot) < 9'(MAX_STEPS))
                count_reg <= CW'(in_data.slot) + 1'b1;
            if (accept && 4'(in_data.contact_index) < 4'(NUM_CONTACTS))
            begin
                if (in_data.func == FUNC_SET_EARLY)
                    early_valid_reg[NW'(in_data.contact_index)] <= 1'b1;
                else if (in_data.func == FUNC_CLEAR_EARLY)
                    early_valid_reg[NW'(in_data.contact_index)] <= 1'b0;
            end
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.func == FUNC_WRITE_STEP
            && 9'(in_data.slot) < 9'(MAX_STEPS))
            step_mem[AW'(in_data.slot)] <= '{side:  in_data.step_side,
                                             swing: in_data.swing_duration,
                                             trans: in_data.transition_duration,
                                             dbl:   in_data.double_contact_duration};
        if (state_reg == S_FETCH)
            rd_reg <= step_mem[idx_reg[AW-1:0]];
        if (accept && in_data.func == FUNC_SET_EARLY
            && 4'(in_data.contact_index) < 4'(NUM_CONTACTS))
            early_mem[NW'(in_data.contact_index)] <= in_data.time_value;
        if (state_reg == S_DONE && out_free)
            out_reg <= '{force_limit: f_reg, phase_code: ph_reg};
        idx_reg      <= idx_next;
        t_reg        <= t_next;
        e_reg        <= e_next;
        has_e_reg    <= has_e_next;
        side_reg     <= side_next;
        early_ok_reg <= early_ok_next;
        ts_reg       <= ts_next;
        te_reg       <= te_next;
        se_reg       <= se_next;
        org_reg      <= org_next;
        ph_reg       <= ph_next;
        f_reg        <= f_next;
        prod_reg     <= prod_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_swing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase_code == PH_SWING |-> out_data.force_limit == '0)
        else $error("swing result with nonzero force");

    a_default_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase_code == PH_DEFAULT
        |-> out_data.force_limit == max_force_reg)
        else $error("default result differs from max force");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.func == FUNC_QUERY |=> in_stall)
        else $error("query transfer did not start a walk");
`endif

endmodule
